// ===== rtl/core/sapq_pkg.sv =====
// sapq_pkg: shared constants, codes and types for the sorted array priority queue
// used by sapq_cell and sorted_array_priority_queue; no dependencies
package sapq_pkg;

  // store geometry
  localparam int unsigned CAPACITY_DEFAULT = 128;
  localparam int unsigned DATA_W           = 32;
  localparam int unsigned FILL_W           = 8;

  // top value reported while the queue is empty
  localparam logic [DATA_W-1:0] EMPTY_TOP = {1'b1, {(DATA_W-1){1'b0}}};

  // operation codes
  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } op_t;

  // status codes
  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_FULL      = 2'd1,
    ST_EMPTY_POP = 2'd2
  } status_t;

  // per-transaction control broadcast to every cell
  typedef struct packed {
    logic push_en;
    logic pop_en;
  } cell_ctl_t;

endpackage

// ===== rtl/core/sorted_array_priority_queue.sv =====
// channel | handshake            | payload
// in      | in_valid / in_stall  | op, value
// out     | out_valid / out_stall| top_value, is_empty, fill_count, status
//
// one transaction per cycle unless stalled: every cell compares the pushed value
// against its own entry in parallel and shifts with its neighbor in the same cycle
// result in the cycle after acceptance: top from head cell, rest in output register
// input stalls only while a result waits and the output is stalled
// reset (synchronous rst) empties the queue and drops any pending result
//
// sorted_array_priority_queue: max priority queue built as a chain of sorted cells
// depends on sapq_pkg and sapq_cell
module sorted_array_priority_queue #(
  parameter int unsigned CAPACITY = sapq_pkg::CAPACITY_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 op,
  input  logic signed [sapq_pkg::DATA_W-1:0]   value,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [sapq_pkg::DATA_W-1:0]   top_value,
  output logic                                 is_empty,
  output logic        [sapq_pkg::FILL_W-1:0]   fill_count,
  output logic        [1:0]                    status
);

  localparam int unsigned COUNT_W = $clog2(CAPACITY + 1);

  logic [COUNT_W-1:0]                  count;
  logic [COUNT_W-1:0]                  count_next;
  logic [COUNT_W+sapq_pkg::FILL_W-1:0] count_wide;
  logic                                accept;
  logic                                is_full;
  logic                                no_entries;
  sapq_pkg::cell_ctl_t                 ctl;
  sapq_pkg::status_t                   status_next;
  logic                                ins_chain   [CAPACITY];
  logic signed [sapq_pkg::DATA_W-1:0]  value_chain [CAPACITY];
  logic signed [sapq_pkg::DATA_W-1:0]  next_chain  [CAPACITY];

  // handshake
  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  assign is_full    = (count == COUNT_W'(CAPACITY));
  assign no_entries = (count == '0);

  // decode the transaction
  always_comb begin
    ctl         = '0;
    status_next = sapq_pkg::ST_DONE;
    count_next  = count;
    case (sapq_pkg::op_t'(op))
      sapq_pkg::OP_PUSH: begin
        if (is_full) begin
          status_next = sapq_pkg::ST_FULL;
        end else begin
          ctl.push_en = accept;
          count_next  = count + COUNT_W'(1);
        end
      end
      sapq_pkg::OP_POP: begin
        if (no_entries) begin
          status_next = sapq_pkg::ST_EMPTY_POP;
        end else begin
          ctl.pop_en = accept;
          count_next = count - COUNT_W'(1);
        end
      end
      default: begin
        status_next = sapq_pkg::ST_DONE;
      end
    endcase
  end

  // chain of sorted cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == CAPACITY - 1) begin : g_last
      assign next_chain[i] = value_chain[i];
    end else begin : g_mid
      assign next_chain[i] = value_chain[i+1];
    end

    if (i == 0) begin : g_head
      sapq_cell #(
        .INDEX   (i),
        .COUNT_W (COUNT_W)
      ) u_cell (
        .clk        (clk),
        .ctl        (ctl),
        .count      (count),
        .push_value (value),
        .prev_ins   (1'b0),
        .prev_value (value),
        .next_value (next_chain[i]),
        .ins        (ins_chain[i]),
        .value      (value_chain[i])
      );
    end else begin : g_body
      sapq_cell #(
        .INDEX   (i),
        .COUNT_W (COUNT_W)
      ) u_cell (
        .clk        (clk),
        .ctl        (ctl),
        .count      (count),
        .push_value (value),
        .prev_ins   (ins_chain[i-1]),
        .prev_value (value_chain[i-1]),
        .next_value (next_chain[i]),
        .ins        (ins_chain[i]),
        .value      (value_chain[i])
      );
    end
  end

  // fill count reported in its low bits only
  assign count_wide = {{sapq_pkg::FILL_W{1'b0}}, count_next};

  // count and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // top comes straight from the head cell, frozen while a result waits
  assign top_value = no_entries ? sapq_pkg::EMPTY_TOP : value_chain[0];

  // result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      is_empty   <= (count_next == '0);
      fill_count <= count_wide[sapq_pkg::FILL_W-1:0];
      status     <= status_next;
    end
  end

`ifndef SYNTHESIS
  // count stays within the store
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= COUNT_W'(CAPACITY))
    else $error("fill count beyond capacity");

  // an empty result reports the empty top
  a_empty_top: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_empty |-> top_value == sapq_pkg::EMPTY_TOP)
    else $error("empty result with a live top value");

  // a push to a full queue leaves the count alone and flags the rejection
  a_full_push: assert property (@(posedge clk) disable iff (rst)
    accept && op == sapq_pkg::OP_PUSH && is_full |=>
      $stable(count) && status == sapq_pkg::ST_FULL)
    else $error("push to full queue not rejected");

  // a pop on an empty queue reports empty and is ignored
  a_empty_pop: assert property (@(posedge clk) disable iff (rst)
    accept && op == sapq_pkg::OP_POP && no_entries |=>
      no_entries && is_empty && status == sapq_pkg::ST_EMPTY_POP)
    else $error("pop on empty queue not ignored");
`endif

endmodule

// ===== rtl/core/sapq_cell.sv =====
// sapq_cell: one slot of the sorted chain, holds a value and trades it with its neighbors
// depends on sapq_pkg
module sapq_cell #(
  parameter int unsigned INDEX   = 0,
  parameter int unsigned COUNT_W = 8
) (
  input  logic                                 clk,
  input  sapq_pkg::cell_ctl_t                  ctl,
  input  logic        [COUNT_W-1:0]            count,
  input  logic signed [sapq_pkg::DATA_W-1:0]   push_value,
  input  logic                                 prev_ins,
  input  logic signed [sapq_pkg::DATA_W-1:0]   prev_value,
  input  logic signed [sapq_pkg::DATA_W-1:0]   next_value,
  output logic                                 ins,
  output logic signed [sapq_pkg::DATA_W-1:0]   value
);

  logic                                 live;
  logic signed [sapq_pkg::DATA_W-1:0]   value_next;

  // slot holds a live entry when it sits below the fill count
  assign live = (COUNT_W'(INDEX) < count);

  // insertion point lies at or above this slot; monotonic along the chain
  assign ins = !live || (push_value > value);

  // push shifts down from the insertion point, pop shifts everything up
  always_comb begin
    value_next = value;
    if (ctl.push_en) begin
      if (prev_ins) begin
        value_next = prev_value;
      end else if (ins) begin
        value_next = push_value;
      end
    end else if (ctl.pop_en) begin
      value_next = next_value;
    end
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule

// ===== verif/sapq_checker.sv =====
// sapq_checker: watches both channels of the sorted array priority queue,
// predicts every result and compares it field by field
// depends on sapq_pkg
module sapq_checker #(
  parameter int unsigned CAPACITY = sapq_pkg::CAPACITY_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  input  logic                               in_stall,
  input  logic                               op,
  input  logic signed [sapq_pkg::DATA_W-1:0] value,
  input  logic                               out_valid,
  input  logic                               out_stall,
  input  logic signed [sapq_pkg::DATA_W-1:0] top_value,
  input  logic                               is_empty,
  input  logic        [sapq_pkg::FILL_W-1:0] fill_count,
  input  logic        [1:0]                  status,
  output int                                 fail_count,
  output int                                 pending,
  output int                                 results_seen,
  output int                                 full_rejects,
  output int                                 empty_pops
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic signed [sapq_pkg::DATA_W-1:0] top;
    logic                               empty;
    logic [sapq_pkg::FILL_W-1:0]        fill;
    sapq_pkg::status_t                  st;
  } queue_result_t;

  // local image of the store, largest value first
  logic signed [sapq_pkg::DATA_W-1:0] ranked[$];
  queue_result_t                      expected_q[$];

  int mismatches = 0;
  int n_results  = 0;
  int n_full     = 0;
  int n_empty    = 0;

  // apply one transaction to the image and return the result it must give
  function automatic queue_result_t apply_op(input sapq_pkg::op_t kind,
                                             input logic signed [sapq_pkg::DATA_W-1:0] v);
    queue_result_t r;
    int unsigned   pos;
    r.st = sapq_pkg::ST_DONE;
    if (kind == sapq_pkg::OP_PUSH) begin
      if (ranked.size() >= CAPACITY) begin
        r.st = sapq_pkg::ST_FULL;
      end else begin
        // equal values keep arrival order: insert after them
        pos = 0;
        while (pos < ranked.size() && !(v > ranked[pos])) pos++;
        ranked.insert(pos, v);
      end
    end else if (ranked.size() == 0) begin
      r.st = sapq_pkg::ST_EMPTY_POP;
    end else begin
      void'(ranked.pop_front());
    end
    r.empty = (ranked.size() == 0);
    r.top   = r.empty ? sapq_pkg::EMPTY_TOP : ranked[0];
    r.fill  = sapq_pkg::FILL_W'(ranked.size());
    return r;
  endfunction

  always @(posedge clk) begin
    queue_result_t want;
    if (rst) begin
      ranked.delete();
      expected_q.delete();
    end else begin
      // result transaction against the oldest prediction
      if (out_valid && !out_stall) begin
        n_results++;
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("unexpected result: top %0d empty %0b fill %0d status %0d",
                     top_value, is_empty, fill_count, status);
        end else begin
          want = expected_q.pop_front();
          if (top_value !== want.top || is_empty !== want.empty ||
              fill_count !== want.fill || status !== want.st) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
              $display("result mismatch, expected: top %0d empty %0b fill %0d status %0d",
                       want.top, want.empty, want.fill, want.st);
              $display("result mismatch, actual:   top %0d empty %0b fill %0d status %0d",
                       top_value, is_empty, fill_count, status);
            end
          end
        end
      end
      // input transaction advances the image
      if (in_valid && !in_stall) begin
        want = apply_op(sapq_pkg::op_t'(op), value);
        if (want.st == sapq_pkg::ST_FULL) n_full++;
        if (want.st == sapq_pkg::ST_EMPTY_POP) n_empty++;
        expected_q.push_back(want);
      end
    end
    pending      <= expected_q.size();
    fail_count   <= mismatches;
    results_seen <= n_results;
    full_rejects <= n_full;
    empty_pops   <= n_empty;
  end

endmodule

// ===== verif/tb.sv =====
// tb: stimulus, clock, reset and verdict for the sorted array priority queue
// depends on sapq_pkg, sorted_array_priority_queue and sapq_checker
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CAP            = sapq_pkg::CAPACITY_DEFAULT;
  localparam int          HOLD_CYCLES    = 300;
  localparam int          WATCHDOG_LIMIT = 2000;
  localparam logic signed [sapq_pkg::DATA_W-1:0] INT_MIN = sapq_pkg::EMPTY_TOP;
  localparam logic signed [sapq_pkg::DATA_W-1:0] INT_MAX =
    {1'b0, {(sapq_pkg::DATA_W-1){1'b1}}};

  logic                               clk       = 1'b0;
  logic                               rst       = 1'b1;
  logic                               in_valid  = 1'b0;
  logic                               op        = sapq_pkg::OP_PUSH;
  logic signed [sapq_pkg::DATA_W-1:0] value     = '0;
  logic                               out_stall = 1'b0;
  logic                               in_stall;
  logic                               out_valid;
  logic signed [sapq_pkg::DATA_W-1:0] top_value;
  logic                               is_empty;
  logic        [sapq_pkg::FILL_W-1:0] fill_count;
  logic        [1:0]                  status;

  int fail_count;
  int pending;
  int results_seen;
  int full_rejects;
  int empty_pops;

  // sender and receiver idling, in percent of cycles
  int idle_pct  = 0;
  int stall_pct = 0;
  // queue depth as seen by the sender, steers fill and drain
  int level     = 0;

  // long output hold-off request, toggled by the sender
  logic hold_go   = 1'b0;
  logic hold_seen = 1'b0;
  int   hold_left = 0;
  int   quiet     = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  sorted_array_priority_queue #(.CAPACITY(CAP)) dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .op         (op),
    .value      (value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .top_value  (top_value),
    .is_empty   (is_empty),
    .fill_count (fill_count),
    .status     (status)
  );

  sapq_checker #(.CAPACITY(CAP)) chk (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .op           (op),
    .value        (value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .top_value    (top_value),
    .is_empty     (is_empty),
    .fill_count   (fill_count),
    .status       (status),
    .fail_count   (fail_count),
    .pending      (pending),
    .results_seen (results_seen),
    .full_rejects (full_rejects),
    .empty_pops   (empty_pops)
  );

  // receiver: random stalls, or a long hold-off when requested
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_go != hold_seen) begin
      hold_seen <= hold_go;
      hold_left <= HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet <= 0;
    end else if (quiet == WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // keys: mostly full range, some extremes, some from a narrow band for ties
  function automatic logic signed [sapq_pkg::DATA_W-1:0] next_key();
    case ($urandom_range(7))
      0: begin
        case ($urandom_range(3))
          0:       return INT_MIN;
          1:       return INT_MAX;
          2:       return '0;
          default: return '1;
        endcase
      end
      1, 2:    return $signed(sapq_pkg::DATA_W'($urandom_range(6))) - 3;
      default: return $signed(sapq_pkg::DATA_W'($urandom()));
    endcase
  endfunction

  // offer one transaction, with random sender gaps, and wait for acceptance
  task automatic offer(input sapq_pkg::op_t kind,
                       input logic signed [sapq_pkg::DATA_W-1:0] v);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    op       <= kind;
    value    <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (kind == sapq_pkg::OP_PUSH) begin
      if (level < CAP) level++;
    end else if (level > 0) begin
      level--;
    end
  endtask

  task automatic churn(input int n, input int push_pct);
    for (int i = 0; i < n; i++)
      offer(($urandom_range(99) < push_pct) ? sapq_pkg::OP_PUSH : sapq_pkg::OP_POP,
            next_key());
  endtask

  // fill to capacity, then push into the full queue
  task automatic fill_up();
    while (level < CAP) offer(sapq_pkg::OP_PUSH, next_key());
    repeat (3) offer(sapq_pkg::OP_PUSH, next_key());
  endtask

  // empty the queue, then pop the empty queue
  task automatic drain();
    while (level > 0) offer(sapq_pkg::OP_POP, next_key());
    repeat (2) offer(sapq_pkg::OP_POP, next_key());
  endtask

  initial begin
    logic signed [sapq_pkg::DATA_W-1:0] corner [10];
    corner = '{INT_MIN, INT_MAX, '0, '1, '0, INT_MAX, 1, INT_MIN,
               32'sh5555_5555, 32'shaaaa_aaaa};
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed: pop on empty, field extremes, ties, pop back past empty
    offer(sapq_pkg::OP_POP, INT_MAX);
    foreach (corner[i]) offer(sapq_pkg::OP_PUSH, corner[i]);
    repeat (12) offer(sapq_pkg::OP_POP, '1);

    // random phases over the idling mixes
    for (int m = 0; m < 4; m++) begin
      case (m)
        0: begin
          idle_pct = 0;
          stall_pct <= 0;
        end
        1: begin
          idle_pct = 60;
          stall_pct <= 0;
        end
        2: begin
          idle_pct = 0;
          stall_pct <= 60;
          hold_go <= ~hold_go;
        end
        default: begin
          idle_pct = 32;
          stall_pct <= 32;
        end
      endcase
      if (m == 0 || m == 3) begin
        churn(50, 50);
        fill_up();
        churn(20, 50);
        drain();
      end else begin
        churn(200, 60);
      end
    end
    in_valid <= 1'b0;

    // let the remaining results drain out
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("run covered %0d push/pop transactions, %0d rejected pushes to a full queue,",
             results_seen, full_rejects);
    $display("%0d pops of an empty queue, four idling mixes and one long output hold-off",
             empty_pops);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d result mismatches", fail_count);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
